// ----- rtl/lfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lfpd_pkg: shared definitions for the line follower PD steering block
// Field widths, configuration register indexes and divider sizing.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int GainW  = 16;
  localparam int SpeedW = 12;
  localparam int TimeW  = 32;
  localparam int ErrW   = 3;
  localparam int CorrW  = 16;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 3;

  // |P*e*dt| < 2^49, plus the derivative term and a sign bit
  localparam int ProdW = GainW + 1 + TimeW;
  localparam int NumW  = ProdW + 2;
  // Dividend is |num| >> 8, divisor is dt
  localparam int DivBits = NumW - 1 - 8;
  localparam int DivCntW = $clog2(DivBits);

  localparam logic [GainW-1:0]  PropGainRst  = 16'd256;
  localparam logic [GainW-1:0]  DerivGainRst = 16'd0;
  localparam logic [SpeedW-1:0] MinSpeedRst  = 12'd0;
  localparam logic [SpeedW-1:0] MaxSpeedRst  = 12'd4095;
  localparam logic              BlackRst     = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_DERIV_GAIN  = 3'd1,
    CFG_MIN_SPEED   = 3'd2,
    CFG_MAX_SPEED   = 3'd3,
    CFG_BLACK_LEVEL = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [SpeedW+5:0] mag;
    logic              fwd;
  } drive_t;

endpackage

// ----- rtl/line_follow_pd_steering.sv -----
// ----------------------------------------------------------------------------
// line_follow_pd_steering: PD steering for a two-motor line follower
// Line error from two sensors, PD correction over the elapsed time through a
// bit-serial divider, and per-motor speed with reflection and clamping.
// ----------------------------------------------------------------------------
// A control step runs multiply, sum, absolute value, divide, saturate, speed,
//   reflect and output phases; the restoring divider gives one quotient bit
//   per cycle, with the dividend shifted out bit by bit.
// A history-reset item (in_action = 1) gives no result; items wait for idle.
// A finished result sits in the output register while the next item runs.
// Synchronous active-low reset clears control, history and time; loads defaults.
module line_follow_pd_steering
  import lfpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgW-1:0]          cfg_wdata,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic                     in_left_level,
  input  logic                     in_right_level,
  input  logic [TimeW-1:0]         in_now_us,
  input  logic [SpeedW-1:0]        in_base_speed,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ErrW-1:0]   out_line_error,
  output logic signed [CorrW-1:0]  out_correction,
  output logic [SpeedW-1:0]        out_left_speed,
  output logic                     out_left_forward,
  output logic [SpeedW-1:0]        out_right_speed,
  output logic                     out_right_forward
);

  localparam int SW = SpeedW + 6;  // signed speed width before clamping

  typedef enum logic [3:0] {
    PH_IDLE, PH_MUL, PH_SUM, PH_ABS, PH_DIV, PH_SAT, PH_SPD, PH_REF, PH_OUT
  } phase_t;

  // configuration registers
  logic [GainW-1:0]  prop_gain_r;
  logic [GainW-1:0]  deriv_gain_r;
  logic [SpeedW-1:0] min_speed_r;
  logic [SpeedW-1:0] max_speed_r;
  logic              black_r;

  // history
  logic signed [ErrW-1:0] prev_err_r;
  logic [TimeW-1:0]       prev_time_r;

  // work registers
  phase_t                    ph_r;
  logic signed [ErrW-1:0]    err_r;
  logic signed [1:0]         dstep_r;
  logic [TimeW-1:0]          dt_r;
  logic [SpeedW-1:0]         base_r;
  logic [ProdW-1:0]          prod_r;
  logic signed [NumW-1:0]    num_r;
  logic                      neg_r;
  logic [TimeW-1:0]          rem_r;
  logic [DivBits-1:0]        dvd_r;
  logic [DivCntW-1:0]        cnt_r;
  logic signed [CorrW-1:0]   corr_r;
  logic signed [SW-1:0]      sl_r, sr_r;
  drive_t                    dl_r, dr_r;

  // output registers
  logic                      out_valid_r;
  logic signed [ErrW-1:0]    out_err_r;
  logic signed [CorrW-1:0]   out_corr_r;
  logic [SpeedW-1:0]         out_lspd_r, out_rspd_r;
  logic                      out_lfwd_r, out_rfwd_r;

  // --------------------------------------------------------------------------
  // Error filter and timestep, evaluated on the accepting edge
  // --------------------------------------------------------------------------
  logic                   left_blk, right_blk;
  logic signed [ErrW-1:0] raw_err, filt_err;
  logic signed [ErrW:0]   err_diff, step_diff;
  logic [TimeW-1:0]       dt_raw, dt_nxt;
  logic                   in_xfer;

  assign in_xfer   = in_valid && !in_stall;
  assign left_blk  = (in_left_level == black_r);
  assign right_blk = (in_right_level == black_r);

  always_comb begin
    if (left_blk && right_blk) begin
      raw_err = 3'sd0;
    end else if (left_blk) begin
      raw_err = 3'sd1;
    end else if (right_blk) begin
      raw_err = -3'sd1;
    end else begin
      // both white: keep turning the way we last drifted
      raw_err = (prev_err_r > 3'sd0) ? 3'sd2 : -3'sd2;
    end
    err_diff  = {prev_err_r[ErrW-1], prev_err_r} - {raw_err[ErrW-1], raw_err};
    // reject a jump of two or more, keep the old error
    filt_err  = (err_diff >= 4'sd2 || err_diff <= -4'sd2) ? prev_err_r : raw_err;
    step_diff = {filt_err[ErrW-1], filt_err} - {prev_err_r[ErrW-1], prev_err_r};
    dt_raw    = in_now_us - prev_time_r;
    dt_nxt    = (dt_raw == '0) ? TimeW'(1) : dt_raw;
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic [GainW:0]         pe;        // P * |e|, |e| is 0, 1 or 2
  logic signed [NumW-1:0] dterm, prod_s, num_nxt;
  logic [NumW-1:0]        mag;
  logic [TimeW:0]         trial;
  logic                   q_ge;
  logic [TimeW-1:0]       rem_nxt;
  logic [CorrW:0]         qsat;
  logic signed [CorrW-1:0] corr_nxt;
  logic signed [SW-1:0]   base_s, corr_s;
  logic                   can_load;

  always_comb begin
    unique case (err_r)
      3'sd2, -3'sd2: pe = {prop_gain_r, 1'b0};
      3'sd1, -3'sd1: pe = {1'b0, prop_gain_r};
      default:       pe = '0;
    endcase

    prod_s = $signed({2'b00, prod_r});
    unique case (dstep_r)
      2'sd1:   dterm = $signed({{(NumW-GainW){1'b0}}, deriv_gain_r});
      -2'sd1:  dterm = -$signed({{(NumW-GainW){1'b0}}, deriv_gain_r});
      default: dterm = '0;
    endcase
    num_nxt = err_r[ErrW-1] ? (dterm - prod_s) : (dterm + prod_s);

    mag = num_r[NumW-1] ? NumW'(-num_r) : NumW'(num_r);

    // restoring division step: bring down one dividend bit
    trial   = {rem_r, dvd_r[DivBits-1]};
    q_ge    = (trial >= {1'b0, dt_r});
    rem_nxt = q_ge ? TimeW'(trial - {1'b0, dt_r}) : trial[TimeW-1:0];

    // saturate quotient to 32768, then to the signed range
    qsat = (dvd_r > DivBits'(32768)) ? 17'd32768 : dvd_r[CorrW:0];
    if (neg_r) begin
      corr_nxt = CorrW'(-qsat);
    end else begin
      corr_nxt = (qsat > 17'd32767) ? 16'sd32767 : $signed(qsat[CorrW-1:0]);
    end

    base_s = $signed({{(SW-SpeedW){1'b0}}, base_r});
    corr_s = SW'(corr_r);

    can_load = !out_valid_r || !out_stall;
  end

  // Below the minimum, reflect about the minimum and run backward
  function automatic drive_t reflect(input logic signed [SW-1:0] s,
                                     input logic [SpeedW-1:0] mn);
    logic signed [SW-1:0] mn_s;
    logic signed [SW-1:0] r;
    drive_t               d;
    mn_s = $signed({{(SW-SpeedW){1'b0}}, mn});
    if (s < mn_s) begin
      r     = s - (mn_s <<< 1);
      d.mag = (r < 0) ? SW'(-r) : SW'(r);
      d.fwd = 1'b0;
    end else begin
      d.mag = SW'(s);
      d.fwd = 1'b1;
    end
    return d;
  endfunction

  // When min is above max, values below min give min and all others give max
  function automatic logic [SpeedW-1:0] clamp(input logic [SW-1:0] v,
                                              input logic [SpeedW-1:0] mn,
                                              input logic [SpeedW-1:0] mx);
    logic [SpeedW-1:0] c;
    if (v < {{(SW-SpeedW){1'b0}}, mn}) begin
      c = mn;
    end else if (v > {{(SW-SpeedW){1'b0}}, mx}) begin
      c = mx;
    end else begin
      c = v[SpeedW-1:0];
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PropGainRst;
      deriv_gain_r <= DerivGainRst;
      min_speed_r  <= MinSpeedRst;
      max_speed_r  <= MaxSpeedRst;
      black_r      <= BlackRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROP_GAIN:   prop_gain_r  <= cfg_wdata[GainW-1:0];
        CFG_DERIV_GAIN:  deriv_gain_r <= cfg_wdata[GainW-1:0];
        CFG_MIN_SPEED:   min_speed_r  <= cfg_wdata[SpeedW-1:0];
        CFG_MAX_SPEED:   max_speed_r  <= cfg_wdata[SpeedW-1:0];
        CFG_BLACK_LEVEL: black_r      <= cfg_wdata[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: one item at a time through multiply, sum, divide and drive
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_IDLE;
      prev_err_r  <= '0;
      prev_time_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // retire the waiting result on its transfer, unless a new one loads now
      if (out_valid_r && !out_stall && ph_r != PH_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (ph_r)
        PH_IDLE: begin
          if (in_xfer) begin
            if (in_action) begin
              // drop the error history, time stays
              prev_err_r <= '0;
            end else begin
              err_r       <= filt_err;
              dstep_r     <= step_diff[1:0];
              dt_r        <= dt_nxt;
              base_r      <= in_base_speed;
              prev_err_r  <= filt_err;
              prev_time_r <= in_now_us;
              ph_r        <= PH_MUL;
            end
          end
        end
        PH_MUL: begin
          prod_r <= ProdW'(pe) * ProdW'(dt_r);
          ph_r   <= PH_SUM;
        end
        PH_SUM: begin
          num_r <= num_nxt;
          ph_r  <= PH_ABS;
        end
        PH_ABS: begin
          // floor(floor(|num|/256)/dt) = floor(|num|/(256*dt))
          neg_r <= num_r[NumW-1];
          dvd_r <= mag[NumW-2:8];
          rem_r <= '0;
          cnt_r <= '0;
          ph_r  <= PH_DIV;
        end
        PH_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[DivBits-2:0], q_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DivCntW'(DivBits - 1)) begin
            ph_r <= PH_SAT;
          end
        end
        PH_SAT: begin
          corr_r <= corr_nxt;
          ph_r   <= PH_SPD;
        end
        PH_SPD: begin
          sl_r <= base_s - corr_s;
          sr_r <= base_s + corr_s;
          ph_r <= PH_REF;
        end
        PH_REF: begin
          dl_r <= reflect(sl_r, min_speed_r);
          dr_r <= reflect(sr_r, min_speed_r);
          ph_r <= PH_OUT;
        end
        PH_OUT: begin
          // hold until the output register is free
          if (can_load) begin
            out_valid_r <= 1'b1;
            out_err_r   <= err_r;
            out_corr_r  <= corr_r;
            out_lspd_r  <= clamp(dl_r.mag, min_speed_r, max_speed_r);
            out_lfwd_r  <= dl_r.fwd;
            out_rspd_r  <= clamp(dr_r.mag, min_speed_r, max_speed_r);
            out_rfwd_r  <= dr_r.fwd;
            ph_r        <= PH_IDLE;
          end
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  assign in_stall          = (ph_r != PH_IDLE);
  assign out_valid         = out_valid_r;
  assign out_line_error    = out_err_r;
  assign out_correction    = out_corr_r;
  assign out_left_speed    = out_lspd_r;
  assign out_left_forward  = out_lfwd_r;
  assign out_right_speed   = out_rspd_r;
  assign out_right_forward = out_rfwd_r;

endmodule

// ----- tb/line_follow_pd_steering_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follow_pd_steering_test: self-checking bench for the PD steering block
// Drives sensor/timestamp steps and history clears through a stalling
// valid/stall channel. The expected steering result for each accepted step
// is typed in a directed row or produced by a cycle-free predictor, and the
// stalling receiver compares the results field by field. A directed table
// comes first, then random phases under different register settings.
// ----------------------------------------------------------------------------
module line_follow_pd_steering_test;
  import lfpd_pkg::*;

  // One steering result as the block presents it
  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [CorrW-1:0] corr;
    logic [SpeedW-1:0]       l_spd;
    logic                    l_fwd;
    logic [SpeedW-1:0]       r_spd;
    logic                    r_fwd;
  } steer_t;

  typedef enum logic [1:0] {ROW_STEP, ROW_CLEAR, ROW_CFG} row_kind_e;

  // Directed row: a register write, a history clear or a control step,
  // with the result typed in where it is obvious (typed = 1)
  typedef struct {
    row_kind_e kind;
    cfg_idx_t  reg_idx;
    int        reg_val;
    int        left;
    int        right;
    longint    now;
    int        base;
    int        typed;
    int        x_err;
    int        x_corr;
    int        x_lspd;
    int        x_lfwd;
    int        x_rspd;
    int        x_rfwd;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CfgIdxW-1:0]       cfg_index;
  logic [CfgW-1:0]          cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_action;
  logic                     in_left_level;
  logic                     in_right_level;
  logic [TimeW-1:0]         in_now_us;
  logic [SpeedW-1:0]        in_base_speed;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [ErrW-1:0]   out_line_error;
  logic signed [CorrW-1:0]  out_correction;
  logic [SpeedW-1:0]        out_left_speed;
  logic                     out_left_forward;
  logic [SpeedW-1:0]        out_right_speed;
  logic                     out_right_forward;

  // Predictor copy of the registers and the error history
  int unsigned      p_gain;
  int unsigned      d_gain;
  int               min_spd;
  int               max_spd;
  logic             black_lvl;
  int               last_err;
  logic [TimeW-1:0] last_us;

  // Steering results still owed by the block, oldest first
  steer_t steer_q[$];

  bit idle_on;
  int fail_cnt  = 0;
  int n_steps   = 0;
  int n_clears  = 0;
  int n_checked = 0;
  int n_writes  = 0;
  int hold_cnt  = 0;

  // Directed table. Reset settings first: sensor cases, jump rejection,
  // zero dt, the clear item, a wrapping timestamp. Then maximum gains,
  // min above max with inverted black level, and a mid-range setting whose
  // results come from the predictor.
  dir_row_t dir_rows [0:30] = '{
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     1, 1, 0,          0,    1, 0,  0,   0,    1, 0,    1},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     1, 0, 10,         4095, 1, 1,  1,   4094, 1, 4095, 1},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     0, 1, 10,         100,  1, 1,  1,   99,   1, 101,  1},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     0, 0, 11,         2,    1, 2,  2,   0,    1, 4,    1},
    '{ROW_CLEAR, CFG_PROP_GAIN,   0,     0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     0, 0, 20,         5,    1, 0,  0,   5,    1, 5,    1},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     0, 1, 20,         0,    1, -1, -1,  1,    1, 1,    0},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     0, 0, 4294967295, 4095, 1, -2, -2,  4095, 1, 4093, 1},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     1, 1, 5,          0,    1, -2, -2,  2,    1, 2,    0},
    '{ROW_CFG,   CFG_PROP_GAIN,   65535, 0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_CFG,   CFG_DERIV_GAIN,  65535, 0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_CLEAR, CFG_PROP_GAIN,   0,     0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     1, 0, 5,          0,    1, 1,  511, 511,  0, 511,  1},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     0, 0, 6,          4095, 1, 2,  767, 3328, 1, 4095, 1},
    '{ROW_CFG,   CFG_MIN_SPEED,   4095,  0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_CFG,   CFG_MAX_SPEED,   0,     0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_CFG,   CFG_BLACK_LEVEL, 0,     0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_CLEAR, CFG_PROP_GAIN,   0,     0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     0, 1, 6,          100,  1, 1,  511, 0,    0, 0,    0},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     0, 0, 7,          4095, 1, 0, -255, 0,    1, 0,    0},
    '{ROW_CFG,   CFG_PROP_GAIN,   300,   0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_CFG,   CFG_DERIV_GAIN,  5000,  0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_CFG,   CFG_MIN_SPEED,   200,   0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_CFG,   CFG_MAX_SPEED,   3000,  0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_CFG,   CFG_BLACK_LEVEL, 1,     0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     1, 0, 1000,       150,  0, 0,  0,   0,    0, 0,    0},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     0, 0, 1003,       3500, 0, 0,  0,   0,    0, 0,    0},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     0, 1, 1003,       200,  0, 0,  0,   0,    0, 0,    0},
    '{ROW_CLEAR, CFG_PROP_GAIN,   0,     0, 0, 0,          0,    0, 0,  0,   0,    0, 0,    0},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     0, 1, 500,        4095, 0, 0,  0,   0,    0, 0,    0},
    '{ROW_STEP,  CFG_PROP_GAIN,   0,     1, 1, 520,        0,    0, 0,  0,   0,    0, 0,    0}
  };

  line_follow_pd_steering DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_left_level     (in_left_level),
    .in_right_level    (in_right_level),
    .in_now_us         (in_now_us),
    .in_base_speed     (in_base_speed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_error    (out_line_error),
    .out_correction    (out_correction),
    .out_left_speed    (out_left_speed),
    .out_left_forward  (out_left_forward),
    .out_right_speed   (out_right_speed),
    .out_right_forward (out_right_forward)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Map a signed motor command to speed magnitude and direction:
  // reflect about the minimum when below it, then clamp.
  function automatic void motor_cmd(input longint s, output logic [SpeedW-1:0] spd,
                                    output logic fwd);
    longint v;
    fwd = (s >= min_spd);
    v = fwd ? s : s - 2 * min_spd;
    if (v < 0) v = -v;
    // when min is above max, values below min give min and all others give max
    if (v < min_spd) v = min_spd;
    else if (v > max_spd) v = max_spd;
    spd = v[SpeedW-1:0];
  endfunction

  // Advance the error history by one item; return 1 and the steering
  // result for a control step, 0 for a history clear.
  function automatic bit predict_steering(input logic act, input logic lft, input logic rgt,
                                          input logic [TimeW-1:0] now,
                                          input logic [SpeedW-1:0] base,
                                          output steer_t res);
    int               e;
    logic             lb;
    logic             rb;
    logic [TimeW-1:0] span;
    longint           dt;
    longint           num;
    longint           q;
    res = '0;
    if (act) begin
      // clear error history, keep the time stamp
      last_err = 0;
      return 1'b0;
    end
    lb = (lft == black_lvl);
    rb = (rgt == black_lvl);
    if (lb && rb) e = 0;
    else if (lb) e = 1;
    else if (rb) e = -1;
    else e = (last_err > 0) ? 2 : -2;
    // reject a jump of two or more, hold the last error instead
    if (last_err - e >= 2 || last_err - e <= -2) e = last_err;
    span = now - last_us;
    dt = span;
    if (dt == 0) dt = 1;
    num = longint'(p_gain) * e * dt + longint'(d_gain) * (e - last_err);
    q = num / (dt * 256);
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    last_err = e;
    last_us  = now;
    res.err  = e[ErrW-1:0];
    res.corr = q[CorrW-1:0];
    motor_cmd(longint'(base) - q, res.l_spd, res.l_fwd);
    motor_cmd(longint'(base) + q, res.r_spd, res.r_fwd);
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  function automatic int pick_val(input int hi);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // Write one register on an idle block and mirror it in the predictor
  task automatic write_reg(input cfg_idx_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CfgW'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PROP_GAIN:   p_gain    = val & 16'hFFFF;
      CFG_DERIV_GAIN:  d_gain    = val & 16'hFFFF;
      CFG_MIN_SPEED:   min_spd   = val & 12'hFFF;
      CFG_MAX_SPEED:   max_spd   = val & 12'hFFF;
      CFG_BLACK_LEVEL: black_lvl = val[0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Present one item after a random gap, hold it until the transfer,
  // then queue its predicted result (or the typed one when given)
  task automatic send_item(input logic act, input logic lft, input logic rgt,
                           input logic [TimeW-1:0] now, input logic [SpeedW-1:0] base,
                           input bit given, input steer_t given_res);
    int     gap;
    steer_t res;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_left_level  <= lft;
    in_right_level <= rgt;
    in_now_us      <= now;
    in_base_speed  <= base;
    do @(posedge clk); while (in_stall);
    if (predict_steering(act, lft, rgt, now, base, res)) begin
      steer_q.push_back(given ? given_res : res);
      n_steps++;
    end else begin
      n_clears++;
    end
  endtask

  // Drop valid, drain all owed results, then let a trailing clear or
  // in-flight step settle before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (steer_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Result receiver: stall a random number of cycles per result,
  // check each transfer against the oldest owed result
  always @(posedge clk) begin
    steer_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_checked++;
      if (steer_q.size() == 0) begin
        $display("%0t ns: result with none owed, expected nothing, actual err %0d corr %0d",
                 $time, out_line_error, out_correction);
        fail_cnt++;
      end else begin
        want = steer_q.pop_front();
        check_field("line_error",    want.err,   out_line_error);
        check_field("correction",    want.corr,  out_correction);
        check_field("left_speed",    want.l_spd, out_left_speed);
        check_field("left_forward",  want.l_fwd, out_left_forward);
        check_field("right_speed",   want.r_spd, out_right_speed);
        check_field("right_forward", want.r_fwd, out_right_forward);
      end
      hold_cnt = idle_on ? $urandom_range(0, 6) : 0;
    end else if (out_valid && hold_cnt > 0) begin
      hold_cnt--;
    end
    out_stall <= (hold_cnt > 0);
  end

  initial begin
    dir_row_t         row;
    steer_t           given;
    int               vals [0:4];
    logic             act;
    logic             lft;
    logic             rgt;
    logic [TimeW-1:0] stamp;
    logic [SpeedW-1:0] base;
    int               sb;

    // hold every input at a known value through reset
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_PROP_GAIN;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_action      = 1'b0;
    in_left_level  = 1'b0;
    in_right_level = 1'b0;
    in_now_us      = '0;
    in_base_speed  = '0;
    out_stall      = 1'b0;
    idle_on        = 1'b1;
    stamp          = 520;

    // predictor starts from the register defaults and empty history
    p_gain    = 256;
    d_gain    = 0;
    min_spd   = 0;
    max_spd   = 4095;
    black_lvl = 1'b1;
    last_err  = 0;
    last_us   = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_CFG: begin
          wait_idle();
          write_reg(row.reg_idx, row.reg_val);
        end
        ROW_CLEAR: begin
          send_item(1'b1, 1'b0, 1'b0, '0, '0, 1'b0, '0);
        end
        default: begin
          given.err   = ErrW'(row.x_err);
          given.corr  = CorrW'(row.x_corr);
          given.l_spd = SpeedW'(row.x_lspd);
          given.l_fwd = 1'(row.x_lfwd);
          given.r_spd = SpeedW'(row.x_rspd);
          given.r_fwd = 1'(row.x_rfwd);
          send_item(1'b0, 1'(row.left), 1'(row.right), TimeW'(row.now),
                    SpeedW'(row.base), row.typed != 0, given);
        end
      endcase
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase)
        0:       vals = '{0, 0, 0, 0, 0};
        1:       vals = '{65535, 65535, 4095, 4095, 1};
        default: begin
          vals[0] = pick_val(65535);
          vals[1] = pick_val(65535);
          vals[2] = pick_val(4095);
          vals[3] = pick_val(4095);
          vals[4] = $urandom_range(0, 1);
        end
      endcase
      for (int j = 0; j < 5; j++) write_reg(cfg_idx_t'(j), vals[j]);
      // one phase runs back to back on both sides
      idle_on = (phase != 3);

      for (int k = 0; k < 50; k++) begin
        act = ($urandom_range(0, 9) == 0);
        lft = 1'($urandom_range(0, 1));
        rgt = 1'($urandom_range(0, 1));
        // mostly short forward steps; sometimes same time, backward or any
        case ($urandom_range(0, 9))
          0:       stamp = $urandom();
          1:       ;
          2:       stamp = stamp - $urandom_range(1, 1000);
          default: stamp = stamp + $urandom_range(1, 2000);
        endcase
        case ($urandom_range(0, 3))
          0: base = $urandom_range(0, 1) ? '1 : '0;
          1: begin
            // hover around the reflection point
            sb = min_spd + int'($urandom_range(0, 1600)) - 800;
            if (sb < 0) sb = 0;
            if (sb > 4095) sb = 4095;
            base = SpeedW'(sb);
          end
          default: base = SpeedW'($urandom_range(0, 4095));
        endcase
        send_item(act, lft, rgt, stamp, base, 1'b0, '0);
      end
    end

    wait_idle();
    $display("Ran %0d control steps and %0d history clears across %0d register writes.",
             n_steps, n_clears, n_writes);
    $display("Compared %0d results field by field, %0d mismatches.", n_checked, fail_cnt);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
